// File: sv/bfdh_pkg.sv
// Shared constants, types and arithmetic helpers of the Bloom filter unit.
package bfdh_pkg;

   localparam int NUM_BITS_W   = 17;
   localparam int NUM_HASHES_W = 8;
   localparam int HASH_W       = 64;
   localparam int CSR_IDX_W    = 1;
   localparam int MAX_BITS_DEF = 65536;

   localparam logic [NUM_BITS_W-1:0]   NUM_BITS_RESET   = 17'd65536;
   localparam logic [NUM_HASHES_W-1:0] NUM_HASHES_RESET = 8'd7;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_NUM_BITS   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_HASHES = 1'd1;

   // Request kinds.
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   // Last step of the shift-subtract remainder (dividend is 65 bits wide).
   localparam logic [6:0] DIV_LAST = 7'd64;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr;
      logic load;
      logic div;
      logic step;
      logic fix;
      logic access;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic div_done;
      logic probes_done;
      logic bit_set;
      logic is_query;
   } sts_type;

   // One step of a restoring remainder: shift in one bit, subtract if needed.
   function automatic logic [NUM_BITS_W-1:0] rem_step(logic [NUM_BITS_W-1:0] r, logic b,
                                                       logic [NUM_BITS_W-1:0] m);
      logic [NUM_BITS_W:0] t;
      t = {r, b};
      if (t >= {1'b0, m}) begin
         t = t - {1'b0, m};
      end
      return t[NUM_BITS_W-1:0];
   endfunction

   // Sum of two residues below m, reduced modulo m.
   function automatic logic [NUM_BITS_W-1:0] add_mod(logic [NUM_BITS_W-1:0] a,
                                                      logic [NUM_BITS_W-1:0] b,
                                                      logic [NUM_BITS_W-1:0] m);
      logic [NUM_BITS_W:0] t;
      t = {1'b0, a} + {1'b0, b};
      if (t >= {1'b0, m}) begin
         t = t - {1'b0, m};
      end
      return t[NUM_BITS_W-1:0];
   endfunction

   // Difference of two residues below m, reduced modulo m.
   function automatic logic [NUM_BITS_W-1:0] sub_mod(logic [NUM_BITS_W-1:0] a,
                                                      logic [NUM_BITS_W-1:0] b,
                                                      logic [NUM_BITS_W-1:0] m);
      logic [NUM_BITS_W:0] t;
      if (a >= b) begin
         t = {1'b0, a} - {1'b0, b};
      end else begin
         t = {1'b0, a} + {1'b0, m} - {1'b0, b};
      end
      return t[NUM_BITS_W-1:0];
   endfunction

endpackage

// File: sv/bfdh_if.sv
// Handshake channel interfaces for requests and responses.
interface bfdh_req_if import bfdh_pkg::*;;
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [HASH_W-1:0] hash_low;
   logic [HASH_W-1:0] hash_high;
   modport source (output valid, req_type, hash_low, hash_high, input ready);
   modport sink   (input valid, req_type, hash_low, hash_high, output ready);
endinterface

interface bfdh_rsp_if;
   logic valid;
   logic ready;
   logic might_contain;
   modport source (output valid, might_contain, input ready);
   modport sink   (input valid, might_contain, output ready);
endinterface

// File: sv/bfdh_datapath.sv
// Datapath: configuration registers, residue unit, probe stepper and bit array.
module bfdh_datapath import bfdh_pkg::*; #(
   parameter int MAX_BITS = MAX_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [NUM_BITS_W-1:0]   csr_wdata,
   input  logic                    req_type,
   input  logic [HASH_W-1:0]       hash_low,
   input  logic [HASH_W-1:0]       hash_high,
   input  cmd_type                 cmd,
   output sts_type                 sts
);
   localparam int AW = $clog2(MAX_BITS);
   localparam logic [NUM_BITS_W-1:0] MOD_CAP =
      (MAX_BITS > 131071) ? 17'h1FFFF : NUM_BITS_W'(MAX_BITS);
   localparam logic [AW-1:0] CLR_LAST = AW'(MAX_BITS - 1);

   logic [NUM_BITS_W-1:0]   num_bits_ff;
   logic [NUM_HASHES_W-1:0] num_hashes_ff;
   logic [NUM_BITS_W-1:0]   mod_ff, mod_in;
   logic [NUM_HASHES_W-1:0] k_ff;
   logic                    kind_ff;
   logic [HASH_W-1:0]       sh_low_ff, sh_high_ff, stride_ff, acc_ff;
   logic                    carry_ff;
   logic [NUM_BITS_W-1:0]   rl_ff, rh_ff, rc_ff, pos_ff;
   logic [6:0]              div_cnt_ff;
   logic [NUM_HASHES_W-1:0] probe_cnt_ff;
   logic [AW-1:0]           clr_cnt_ff;
   logic                    rdata_ff;
   logic                    mem [MAX_BITS];
   logic [HASH_W:0]         acc_sum;
   logic                    b_low, b_high, b_c;
   logic                    mem_we;
   logic [AW-1:0]           mem_addr;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_bits_ff   <= NUM_BITS_RESET;
         num_hashes_ff <= NUM_HASHES_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_NUM_BITS:   num_bits_ff   <= csr_wdata;
            REG_NUM_HASHES: num_hashes_ff <= csr_wdata[NUM_HASHES_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective modulus: zero counts as one, and it never exceeds the array.
   always_comb begin
      mod_in = num_bits_ff;
      if (num_bits_ff == '0) begin
         mod_in = NUM_BITS_W'(1);
      end else if (num_bits_ff > MOD_CAP) begin
         mod_in = MOD_CAP;
      end
   end

   // Dividend bits of the three remainder lanes; the third lane divides 2^64.
   assign b_low  = (div_cnt_ff == '0) ? 1'b0 : sh_low_ff[HASH_W-1];
   assign b_high = (div_cnt_ff == '0) ? 1'b0 : sh_high_ff[HASH_W-1];
   assign b_c    = (div_cnt_ff == '0);
   assign acc_sum = {1'b0, acc_ff} + {1'b0, stride_ff};

   // Item load, residue computation and probe stepping.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mod_ff       <= mod_in;
         k_ff         <= num_hashes_ff;
         kind_ff      <= req_type;
         sh_low_ff    <= hash_low;
         sh_high_ff   <= hash_high;
         stride_ff    <= hash_high;
         acc_ff       <= hash_low;
         carry_ff     <= 1'b0;
         rl_ff        <= '0;
         rh_ff        <= '0;
         rc_ff        <= '0;
         div_cnt_ff   <= '0;
         probe_cnt_ff <= '0;
      end else if (cmd.div) begin
         rl_ff      <= rem_step(rl_ff, b_low, mod_ff);
         rh_ff      <= rem_step(rh_ff, b_high, mod_ff);
         rc_ff      <= rem_step(rc_ff, b_c, mod_ff);
         div_cnt_ff <= div_cnt_ff + 7'd1;
         if (div_cnt_ff != '0) begin
            sh_low_ff  <= {sh_low_ff[HASH_W-2:0], 1'b0};
            sh_high_ff <= {sh_high_ff[HASH_W-2:0], 1'b0};
         end
         // The probe position starts as the residue of the base.
         pos_ff <= rem_step(rl_ff, b_low, mod_ff);
      end else if (cmd.step) begin
         acc_ff       <= acc_sum[HASH_W-1:0];
         carry_ff     <= acc_sum[HASH_W];
         pos_ff       <= add_mod(pos_ff, rh_ff, mod_ff);
         probe_cnt_ff <= probe_cnt_ff + 1'b1;
      end else if (cmd.fix) begin
         // A wrap of the 64-bit sum drops 2^64, whose residue is rc.
         if (carry_ff) begin
            pos_ff <= sub_mod(pos_ff, rc_ff, mod_ff);
         end
      end
   end

   // Clearing pass counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // Bit array with one port: clear, set or read.
   assign mem_we   = cmd.clr | (cmd.access & (kind_ff == REQ_INSERT));
   assign mem_addr = cmd.clr ? clr_cnt_ff : AW'(pos_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= ~cmd.clr;
      end
      if (cmd.access) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   assign sts.clear_done  = (clr_cnt_ff == CLR_LAST);
   assign sts.div_done    = (div_cnt_ff == DIV_LAST);
   assign sts.probes_done = (probe_cnt_ff == k_ff);
   assign sts.bit_set     = rdata_ff;
   assign sts.is_query    = (kind_ff == REQ_QUERY);

endmodule

// File: sv/bfdh_controller.sv
// Controller: sequences clearing, residue computation, probes and the response register.
module bfdh_controller import bfdh_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output logic    rsp_might_contain,
   input  sts_type sts,
   output cmd_type cmd
);
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_STEP   = 3'd3;
   localparam logic [2:0] S_FIX    = 3'd4;
   localparam logic [2:0] S_ACCESS = 3'd5;
   localparam logic [2:0] S_CHECK  = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       hit_ff, hit_in;
   logic       rsp_valid_ff, rsp_data_ff;
   logic       rsp_load;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      hit_in   = hit_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               hit_in   = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div = 1'b1;
            if (sts.div_done) begin
               if (!sts.probes_done) begin
                  state_in = S_STEP;
               end else begin
                  state_in = sts.is_query ? S_DONE : S_IDLE;
               end
            end
         end
         S_STEP: begin
            cmd.step = 1'b1;
            state_in = S_FIX;
         end
         S_FIX: begin
            cmd.fix  = 1'b1;
            state_in = S_ACCESS;
         end
         S_ACCESS: begin
            cmd.access = 1'b1;
            if (sts.is_query) begin
               state_in = S_CHECK;
            end else begin
               state_in = sts.probes_done ? S_IDLE : S_STEP;
            end
         end
         S_CHECK: begin
            // Stop at the first clear bit.
            if (!sts.bit_set) begin
               hit_in   = 1'b0;
               state_in = S_DONE;
            end else begin
               state_in = sts.probes_done ? S_DONE : S_STEP;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
      hit_ff <= hit_in;
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff <= hit_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_might_contain = rsp_data_ff;

endmodule

// File: sv/bloom_filter_double_hash_unit.sv
// Bloom filter unit with double hashing: one request at a time, responses for queries.
// After the cycle that accepts an item, a bit-serial remainder unit over 65 dividend bits
// reduces its hash halves modulo the filter size; then each probe runs step, wrap fix and
// bit array access, and for queries the check, with a query ending at its first clear bit
// and then loading its response, which waits while the response is stalled. After reset the
// bit array is cleared one bit per cycle, during which no item is taken; configuration
// writes are taken at any time but must only be issued while the unit is idle.
module bloom_filter_double_hash_unit import bfdh_pkg::*; #(
   parameter int MAX_BITS = MAX_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   bfdh_req_if.sink              req_ch,
   bfdh_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [NUM_BITS_W-1:0] csr_wdata
);
   cmd_type cmd;
   sts_type sts;

   bfdh_controller u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_might_contain (rsp_ch.might_contain),
      .sts               (sts),
      .cmd               (cmd)
   );

   bfdh_datapath #(.MAX_BITS(MAX_BITS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_type  (req_ch.req_type),
      .hash_low  (req_ch.hash_low),
      .hash_high (req_ch.hash_high),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// File: sv/bfdh_checker.sv
// Port-level assertions for the Bloom filter unit and their binding.
module bfdh_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_might_contain
);
   // The unit is busy clearing right after reset.
   a_clear_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request ready right after reset");

   // One item at a time: an accepted item blocks the next cycle.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request ready right after an accept");

   // A stalled response stays.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_might_contain))
      else $error("response changed while stalled");

endmodule

bind bloom_filter_double_hash_unit bfdh_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_might_contain (rsp_ch.might_contain)
);
